// ----- sv/mp3ffh_pkg.sv -----
// Package for the MP3 first frame header scanner.
// Holds beat types, header decode tables and divider sizing; no dependencies.
`timescale 1ns / 1ps

package mp3ffh_pkg;

	localparam int POSITION_BITS_DEF    = 32;
	localparam int TAG_CHECK_OFFSET_DEF = 36;

	// Frame size quotient never exceeds 1440, so 11 quotient bits suffice
	localparam int QUO_BITS = 11;
	localparam int NUM_BITS = 26;
	localparam int DEN_BITS = 16;
	localparam int CNT_BITS = $clog2(QUO_BITS + 1);

	localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
	localparam logic [7:0]  SYNC_MASK    = 8'hE0;
	localparam logic [7:0]  NOCRC_BYTE   = 8'hFB;
	localparam logic [23:0] ID3_MARK     = 24'h494433;
	localparam logic [31:0] XING_MARK    = 32'h58696E67;
	localparam logic [31:0] INFO_MARK    = 32'h496E666F;
	localparam logic [28:0] TAG_HDR_LEN  = 29'd10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic        found;
		logic [31:0] header_offset;
		logic [31:0] audio_start;
		logic [1:0]  version_code;
		logic [1:0]  layer_code;
		logic [15:0] sample_rate_hz;
		logic [8:0]  bitrate_kbps;
		logic [10:0] frame_pcm_count;
		logic [10:0] frame_size_bytes;
		logic        vbr_tag;
		logic        layer3_nocrc;
		logic        id3v2_present;
	} result_t;

	// Scan outcome handed from the byte scanner to the sequencer
	typedef struct packed {
		logic        emit;
		logic        have;
		logic        vbr;
		logic        tag_seen;
		logic [31:0] header;
		logic [31:0] offset;
	} scan_res_t;

	function automatic logic [15:0] rate_hz(input logic [1:0] idx);
		logic [15:0] r;
		unique case (idx)
			2'd0:    r = 16'd44100;
			2'd1:    r = 16'd48000;
			2'd2:    r = 16'd32000;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] kbps_val(input logic [3:0] idx);
		logic [8:0] k;
		unique case (idx)
			4'd1:    k = 9'd32;
			4'd2:    k = 9'd40;
			4'd3:    k = 9'd48;
			4'd4:    k = 9'd56;
			4'd5:    k = 9'd64;
			4'd6:    k = 9'd80;
			4'd7:    k = 9'd96;
			4'd8:    k = 9'd112;
			4'd9:    k = 9'd128;
			4'd10:   k = 9'd160;
			4'd11:   k = 9'd192;
			4'd12:   k = 9'd224;
			4'd13:   k = 9'd256;
			4'd14:   k = 9'd320;
			default: k = 9'd0;
		endcase
		return k;
	endfunction

	// 144 * kbps * 1000 for each bitrate index
	function automatic logic [NUM_BITS-1:0] frame_num(input logic [3:0] idx);
		logic [NUM_BITS-1:0] n;
		unique case (idx)
			4'd1:    n = NUM_BITS'(4608000);
			4'd2:    n = NUM_BITS'(5760000);
			4'd3:    n = NUM_BITS'(6912000);
			4'd4:    n = NUM_BITS'(8064000);
			4'd5:    n = NUM_BITS'(9216000);
			4'd6:    n = NUM_BITS'(11520000);
			4'd7:    n = NUM_BITS'(13824000);
			4'd8:    n = NUM_BITS'(16128000);
			4'd9:    n = NUM_BITS'(18432000);
			4'd10:   n = NUM_BITS'(23040000);
			4'd11:   n = NUM_BITS'(27648000);
			4'd12:   n = NUM_BITS'(32256000);
			4'd13:   n = NUM_BITS'(36864000);
			4'd14:   n = NUM_BITS'(46080000);
			default: n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [10:0] frame_samples(input logic [1:0] ver, input logic [1:0] lay);
		logic [10:0] s;
		s = 11'd0;
		if (ver == 2'd3) begin
			if (lay == 2'd1 || lay == 2'd2) s = 11'd1152;
			else if (lay == 2'd3) s = 11'd384;
		end else begin
			if (lay == 2'd3) s = 11'd384;
			else if (lay == 2'd2) s = 11'd1152;
			else if (lay == 2'd1) s = 11'd576;
		end
		return s;
	endfunction

endpackage

// ----- sv/mp3ffh_stream_if.sv -----
// Valid/ready stream channel carrying one payload of type T per beat.
// Used for the byte input and result output; no dependencies.
`timescale 1ns / 1ps

interface mp3ffh_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/mp3ffh_div.sv -----
// Iterative restoring divider for the frame size, one quotient bit per cycle.
// Depends on mp3ffh_pkg for operand and quotient widths.
`timescale 1ns / 1ps

module mp3ffh_div
	import mp3ffh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                done,
	output logic [QUO_BITS-1:0] quo
);

	logic                busy_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [QUO_BITS-1:0] quo_q;
	logic [DEN_BITS:0]   trial;
	logic                ge;

	// Shift in the next dividend bit and test against the divisor
	assign trial = {rem_q, quo_q[QUO_BITS-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign done  = busy_q && (cnt_q == '0);
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(QUO_BITS);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Quotient fits QUO_BITS, so the upper dividend part starts below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_BITS'(num[NUM_BITS-1:QUO_BITS]);
			quo_q <= num[QUO_BITS-1:0];
			den_q <= den;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? DEN_BITS'(trial - {1'b0, den_q}) : trial[DEN_BITS-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], ge};
		end
	end

endmodule

// ----- sv/mp3ffh_scan.sv -----
// Byte scanner: ID3v2 skip, frame sync hunt, header capture and VBR tag check.
// Depends on mp3ffh_pkg for beat and scan result types.
`timescale 1ns / 1ps

module mp3ffh_scan
	import mp3ffh_pkg::*;
#(
	parameter int POSITION_BITS    = POSITION_BITS_DEF,
	parameter int TAG_CHECK_OFFSET = TAG_CHECK_OFFSET_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  in_beat_t  beat,
	output scan_res_t res
);

	localparam int P  = POSITION_BITS;
	localparam int CW = (P > 30) ? P : 30;
	localparam int EW = P + 8;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEAD,
		PH_TAGSIZE,
		PH_HUNT,
		PH_TAGCHK,
		PH_DONE
	} phase_t;

	phase_t      phase_q, ph, ph_n;
	logic [P-1:0] pos_q, pos, pos_n;
	logic [31:0]  win_q, win_n;
	logic [28:0]  skip_q, skip, skip_n;
	logic [P-1:0] fstart_q, fstart, fstart_n;
	logic [31:0]  hdr_q, hdr, hdr_n;
	logic         tag_q, tag_n;
	logic         active;
	logic         pos_sat;
	logic         sync_hit;
	logic         chk_hit;
	logic         vbr;
	logic [27:0]  id3_len;
	logic [31:0]  off32;
	logic         res_emit;
	logic         res_have;
	logic         res_vbr;

	// A first byte restarts everything before the byte is processed
	always_comb begin
		ph     = beat.first_byte ? PH_HEAD : phase_q;
		pos    = beat.first_byte ? '0 : pos_q;
		skip   = beat.first_byte ? '0 : skip_q;
		fstart = beat.first_byte ? '0 : fstart_q;
		hdr    = beat.first_byte ? '0 : hdr_q;
		win_n  = {(beat.first_byte ? 24'd0 : win_q[23:0]), beat.data_byte};
	end

	assign active   = (ph != PH_IDLE) && (ph != PH_DONE);
	assign pos_sat  = (pos == '1);
	assign id3_len  = {win_n[30:24], win_n[22:16], win_n[14:8], win_n[6:0]};
	assign sync_hit = !pos_sat
		&& (CW'(pos) >= CW'(skip) + CW'(3))
		&& (win_n[31:24] == SYNC_BYTE)
		&& ((win_n[23:16] & SYNC_MASK) == SYNC_MASK);
	assign chk_hit  = !pos_sat
		&& (EW'(pos) == EW'(fstart) + EW'(TAG_CHECK_OFFSET + 3));
	assign vbr      = (win_n == XING_MARK) || (win_n == INFO_MARK);

	// Advance the scan phase for this byte
	always_comb begin
		ph_n     = ph;
		skip_n   = skip;
		fstart_n = fstart;
		hdr_n    = hdr;
		tag_n    = beat.first_byte ? 1'b0 : tag_q;
		res_emit = 1'b0;
		res_have = 1'b0;
		res_vbr  = 1'b0;
		unique case (ph)
			PH_HEAD: begin
				if (pos == P'(2)) begin
					if (win_n[23:0] == ID3_MARK) begin
						tag_n = 1'b1;
						ph_n  = PH_TAGSIZE;
					end else begin
						ph_n = PH_HUNT;
					end
				end
			end
			PH_TAGSIZE: begin
				if (pos == P'(9)) begin
					skip_n = {1'b0, id3_len} + TAG_HDR_LEN;
					ph_n   = PH_HUNT;
				end
			end
			PH_HUNT: begin
				if (sync_hit) begin
					hdr_n    = win_n;
					fstart_n = pos - P'(3);
					ph_n     = PH_TAGCHK;
				end
			end
			PH_TAGCHK: begin
				if (chk_hit) begin
					res_emit = 1'b1;
					res_have = 1'b1;
					res_vbr  = vbr;
					ph_n     = PH_DONE;
				end
			end
			default: begin
			end
		endcase
		// Close out the file at its final byte
		if (!res_emit && beat.last_byte) begin
			res_emit = 1'b1;
			res_have = (ph_n == PH_TAGCHK);
			ph_n     = PH_DONE;
		end
		if (!active) res_emit = 1'b0;
	end

	assign pos_n = pos_sat ? pos : pos + 1'b1;

	// Saturate the frame offset to 32 bits
	generate
		if (P > 32) begin : g_sat
			assign off32 = (|fstart_n[P-1:32]) ? 32'hFFFF_FFFF : fstart_n[31:0];
		end else begin : g_ext
			assign off32 = 32'(fstart_n);
		end
	endgenerate

	assign res = {res_emit, res_have, res_vbr, tag_n, hdr_n, off32};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			win_q    <= '0;
			skip_q   <= '0;
			fstart_q <= '0;
			hdr_q    <= '0;
			tag_q    <= 1'b0;
		end else if (take && active) begin
			phase_q  <= ph_n;
			pos_q    <= pos_n;
			win_q    <= win_n;
			skip_q   <= skip_n;
			fstart_q <= fstart_n;
			hdr_q    <= hdr_n;
			tag_q    <= tag_n;
		end
	end

endmodule

// ----- sv/mp3_first_frame_header_scanner_unit.sv -----
// MP3 first frame header scanner: takes one file byte per beat and reports the first frame.
// Sequence: a result with a known sample rate goes through the restoring divider (one frame size
// bit per cycle) before it is offered on result_out; any other result is offered directly.
// Throughput: 1 byte per cycle while scanning; input stalls while dividing or holding a result.
// Reset: arst_n clears the scan to idle; bytes are ignored until one marked first_byte.
// Depends on mp3ffh_pkg, mp3ffh_stream_if, mp3ffh_scan and mp3ffh_div.
`timescale 1ns / 1ps

module mp3_first_frame_header_scanner_unit
	import mp3ffh_pkg::*;
#(
	parameter int POSITION_BITS    = POSITION_BITS_DEF,
	parameter int TAG_CHECK_OFFSET = TAG_CHECK_OFFSET_DEF
) (
	input logic              clk,
	input logic              arst_n,
	mp3ffh_stream_if.sink    byte_in,
	mp3ffh_stream_if.source  result_out
);

	typedef enum logic [1:0] {
		S_TAKE,
		S_DIV,
		S_SEND
	} state_t;

	state_t        state_q;
	result_t       out_q;
	scan_res_t     res;
	in_beat_t      beat;
	logic          take;
	logic          div_start;
	logic          div_done;
	logic [QUO_BITS-1:0] quo;
	logic [1:0]    rate_idx;
	logic [3:0]    kbps_idx;
	logic [15:0]   rate;
	logic [32:0]   audio_sum;

	assign beat           = byte_in.data;
	assign byte_in.ready  = (state_q == S_TAKE);
	assign take           = byte_in.valid && byte_in.ready;
	assign result_out.valid = (state_q == S_SEND);
	assign result_out.data  = out_q;

	assign rate_idx  = res.header[11:10];
	assign kbps_idx  = res.header[15:12];
	assign rate      = rate_hz(rate_idx);
	assign div_start = take && res.emit && res.have && (rate != '0);
	assign audio_sum = {1'b0, out_q.header_offset} + 33'(quo);

	mp3ffh_scan #(
		.POSITION_BITS    (POSITION_BITS),
		.TAG_CHECK_OFFSET (TAG_CHECK_OFFSET)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.beat   (beat),
		.res    (res)
	);

	mp3ffh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (frame_num(kbps_idx)),
		.den    (rate),
		.done   (div_done),
		.quo    (quo)
	);

	// Sequence: capture the decoded header, run the divider, hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TAKE;
			out_q   <= '0;
		end else begin
			unique case (state_q)
				S_TAKE: begin
					if (take && res.emit) begin
						out_q.found             <= res.have;
						out_q.header_offset     <= res.have ? res.offset : 32'd0;
						out_q.audio_start       <= res.have ? res.offset : 32'd0;
						out_q.version_code      <= res.have ? res.header[20:19] : 2'd0;
						out_q.layer_code        <= res.have ? res.header[18:17] : 2'd0;
						out_q.sample_rate_hz    <= res.have ? rate : 16'd0;
						out_q.bitrate_kbps      <= res.have ? kbps_val(kbps_idx) : 9'd0;
						out_q.frame_pcm_count   <= res.have ?
							frame_samples(res.header[20:19], res.header[18:17]) : 11'd0;
						out_q.frame_size_bytes  <= 11'd0;
						out_q.vbr_tag           <= res.have && res.vbr;
						out_q.layer3_nocrc      <= res.have && (res.header[23:16] == NOCRC_BYTE);
						out_q.id3v2_present     <= res.tag_seen;
						state_q <= div_start ? S_DIV : S_SEND;
					end
				end
				S_DIV: begin
					if (div_done) begin
						out_q.frame_size_bytes <= quo;
						out_q.audio_start      <= audio_sum[32] ? 32'hFFFF_FFFF : audio_sum[31:0];
						state_q <= S_SEND;
					end
				end
				S_SEND: begin
					if (result_out.ready) state_q <= S_TAKE;
				end
				default: state_q <= S_TAKE;
			endcase
		end
	end

endmodule
